// File: hw/rtl/usvg_pkg.sv
// ----------------------------------------------------------------------------
// usvg_pkg
// Types, widths and constants shared by the UV-sphere vertex generator cells.
// ----------------------------------------------------------------------------
package usvg_pkg;

    localparam int DIV_W        = 25;  // remainder width of the angle divider
    localparam int QUO_W        = 17;  // quotient width (angle plus one wrap bit)
    localparam int DEN_W        = 9;   // twice the largest count
    localparam int DIV_STEPS    = 17;
    localparam int XY_W         = 34;  // Q2.30 plus headroom
    localparam int Z_W          = 17;
    localparam int TRIG_W       = 32;  // clamped Q2.30
    localparam int CORDIC_STEPS = 16;
    localparam int CORNER_W     = 16;
    localparam int POS_W        = 17;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30     = 34'sd1073741824;

    localparam logic [1:0] REG_STACK_COUNT   = 2'd0;
    localparam logic [1:0] REG_SLICE_COUNT   = 2'd1;
    localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

    typedef struct packed {
        logic                in_range;
        logic                quad_valid;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_d;
    } meta_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
    } div_lane_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
        logic                   zero;
    } cordic_lane_t;

    // Arctangent of 2^-k in units of 2^-16 turn
    function automatic logic signed [Z_W-1:0] atan_step(input int k);
        logic signed [Z_W-1:0] a;
        case (k)
            0:       a = 17'sd8192;
            1:       a = 17'sd4836;
            2:       a = 17'sd2555;
            3:       a = 17'sd1297;
            4:       a = 17'sd651;
            5:       a = 17'sd326;
            6:       a = 17'sd163;
            7:       a = 17'sd81;
            8:       a = 17'sd41;
            9:       a = 17'sd20;
            10:      a = 17'sd10;
            11:      a = 17'sd5;
            12:      a = 17'sd3;
            13:      a = 17'sd1;
            14:      a = 17'sd1;
            default: a = 17'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/usvg_div_cell.sv
// ----------------------------------------------------------------------------
// usvg_div_cell
// One restoring-division cell: settles one quotient bit for both angle lanes.
// ----------------------------------------------------------------------------
module usvg_div_cell #(
    parameter int BIT = 0
) (
    input  logic                clk,
    input  logic                en,
    input  usvg_pkg::div_lane_t phi_in,
    input  usvg_pkg::div_lane_t theta_in,
    input  usvg_pkg::meta_t     meta_in,
    output usvg_pkg::div_lane_t phi_out,
    output usvg_pkg::div_lane_t theta_out,
    output usvg_pkg::meta_t     meta_out
);

    usvg_pkg::div_lane_t phi_reg, phi_next;
    usvg_pkg::div_lane_t theta_reg, theta_next;
    usvg_pkg::meta_t     meta_reg;

    function automatic usvg_pkg::div_lane_t div_step(input usvg_pkg::div_lane_t l);
        usvg_pkg::div_lane_t          r;
        logic [usvg_pkg::DIV_W-1:0]   trial;
        r     = l;
        trial = usvg_pkg::DIV_W'(l.den) << BIT;
        if (l.rem >= trial)
        begin
            r.rem      = l.rem - trial;
            r.quo[BIT] = 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        phi_next   = div_step(phi_in);
        theta_next = div_step(theta_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg   <= phi_next;
            theta_reg <= theta_next;
            meta_reg  <= meta_in;
        end
    end

    assign phi_out   = phi_reg;
    assign theta_out = theta_reg;
    assign meta_out  = meta_reg;

endmodule

// File: hw/rtl/usvg_cordic_cell.sv
// ----------------------------------------------------------------------------
// usvg_cordic_cell
// One rotation step of the CORDIC for both angle lanes.
// ----------------------------------------------------------------------------
module usvg_cordic_cell #(
    parameter int K = 0
) (
    input  logic                   clk,
    input  logic                   en,
    input  usvg_pkg::cordic_lane_t phi_in,
    input  usvg_pkg::cordic_lane_t theta_in,
    input  usvg_pkg::meta_t        meta_in,
    output usvg_pkg::cordic_lane_t phi_out,
    output usvg_pkg::cordic_lane_t theta_out,
    output usvg_pkg::meta_t        meta_out
);

    usvg_pkg::cordic_lane_t phi_reg, phi_next;
    usvg_pkg::cordic_lane_t theta_reg, theta_next;
    usvg_pkg::meta_t        meta_reg;

    function automatic usvg_pkg::cordic_lane_t rot_step(input usvg_pkg::cordic_lane_t l);
        usvg_pkg::cordic_lane_t             r;
        logic signed [usvg_pkg::XY_W-1:0]   dx;
        logic signed [usvg_pkg::XY_W-1:0]   dy;
        r  = l;
        dx = l.y >>> K;
        dy = l.x >>> K;
        if (!l.z[usvg_pkg::Z_W-1])
        begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - usvg_pkg::atan_step(K);
        end
        else
        begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + usvg_pkg::atan_step(K);
        end
        return r;
    endfunction

    always_comb
    begin
        phi_next   = rot_step(phi_in);
        theta_next = rot_step(theta_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg   <= phi_next;
            theta_reg <= theta_next;
            meta_reg  <= meta_in;
        end
    end

    assign phi_out   = phi_reg;
    assign theta_out = theta_reg;
    assign meta_out  = meta_reg;

endmodule

// File: hw/rtl/uv_sphere_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// UV-sphere vertex, normal and quad-index generator, one grid point a beat.
// ----------------------------------------------------------------------------
// Each input beat names a grid point (stack, slice). The block returns the
// Q8.8 position, the Q1.NORMAL_FRAC_BITS unit normal and the four corner
// indices of the quad at that point, one result beat per input beat, in
// order. It takes one beat every clock cycle while in_ready is high. The
// beat passes 38 register stages: one capture stage, 17 restoring-division
// cells that form both angles, 16 CORDIC cells, one quadrant/clamp stage,
// two multiplier stages and the output register. Every stage holds its
// beat when the stage behind it is full and stalled, so bubbles are squeezed
// out and the input keeps flowing while a result waits. Write configuration
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core #(
    parameter int MAX_DIVISIONS    = 255,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [15:0]                 cfg_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  stack_index,
    input  logic [7:0]                  slice_index,
    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [16:0]          pos_x,
    output logic signed [16:0]          pos_y,
    output logic signed [16:0]          pos_z,
    output logic signed [NORMAL_FRAC_BITS+1:0] norm_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] norm_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] norm_z,
    output logic [15:0]                 corner_a,
    output logic [15:0]                 corner_b,
    output logic [15:0]                 corner_c,
    output logic [15:0]                 corner_d,
    output logic                        quad_valid,
    output logic                        in_range
);

    localparam int NORM_W   = NORMAL_FRAC_BITS + 2;
    localparam int NSHIFT   = 30 - NORMAL_FRAC_BITS;
    localparam int MAXC     = (MAX_DIVISIONS > 255) ? 255 : MAX_DIVISIONS;
    localparam int DIV_BASE = 1;
    localparam int COR_BASE = DIV_BASE + usvg_pkg::DIV_STEPS;
    localparam int POST_STG = COR_BASE + usvg_pkg::CORDIC_STEPS;
    localparam int M1_STG   = POST_STG + 1;
    localparam int M2_STG   = M1_STG + 1;
    localparam int OUT_STG  = M2_STG + 1;
    localparam int NSTG     = OUT_STG + 1;
    localparam int PROD_W   = usvg_pkg::TRIG_W + 17;

    localparam logic signed [32:0] NRND = 33'((34'd1 << NSHIFT) >> 1);
    localparam logic signed [63:0] URND = 64'sd536870912;
    localparam logic signed [PROD_W-1:0] PRND = PROD_W'(64'sd536870912);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  stack_count_reg;
    logic [7:0]  slice_count_reg;
    logic [15:0] sphere_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg   <= 8'd16;
            slice_count_reg   <= 8'd32;
            sphere_radius_reg <= 16'd256;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                usvg_pkg::REG_STACK_COUNT:   stack_count_reg   <= cfg_data[7:0];
                usvg_pkg::REG_SLICE_COUNT:   slice_count_reg   <= cfg_data[7:0];
                usvg_pkg::REG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data;
                default:                     ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stall chain: a stage advances when it is empty or its successor does
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG:0]   en;

    always_comb
    begin
        en[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        for (int k = 0; k < NSTG; k++)
        begin
            if (en[k])
                vld_next[k] = (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k-1];
            else
                vld_next[k] = vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------
    // Capture stage: grid check, corner indices, division operands
    // ------------------------------------------------------------------
    logic [7:0]          st, sl;
    logic                grid_ok, quad_ok;
    logic [15:0]         a16, b16;
    usvg_pkg::meta_t     meta0_next, meta0_reg;
    usvg_pkg::div_lane_t dphi0_next, dphi0_reg, dth0_next, dth0_reg;

    always_comb
    begin
        st = (stack_count_reg > 8'(MAXC)) ? 8'(MAXC) : stack_count_reg;
        sl = (slice_count_reg > 8'(MAXC)) ? 8'(MAXC) : slice_count_reg;
        grid_ok = (st != 8'd0) && (sl != 8'd0) && (stack_index <= st) && (slice_index <= sl);
        quad_ok = grid_ok && (stack_index < st) && (slice_index < sl);
        a16     = 16'(stack_index) * (16'(sl) + 16'd1) + 16'(slice_index);
        b16     = a16 + 16'(sl) + 16'd1;

        meta0_next.in_range   = grid_ok;
        meta0_next.quad_valid = quad_ok;
        meta0_next.corner_a   = grid_ok ? a16 : 16'd0;
        meta0_next.corner_b   = quad_ok ? b16 : 16'd0;
        meta0_next.corner_c   = quad_ok ? a16 + 16'd1 : 16'd0;
        meta0_next.corner_d   = quad_ok ? b16 + 16'd1 : 16'd0;

        // phi = (i*2^16 + st) / (2*st), theta = (j*2^17 + sl) / (2*sl)
        dphi0_next.rem = usvg_pkg::DIV_W'({stack_index, 16'h0000}) + usvg_pkg::DIV_W'(st);
        dphi0_next.quo = '0;
        dphi0_next.den = {st, 1'b0};
        dth0_next.rem  = usvg_pkg::DIV_W'({slice_index, 17'd0}) + usvg_pkg::DIV_W'(sl);
        dth0_next.quo  = '0;
        dth0_next.den  = {sl, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            meta0_reg <= meta0_next;
            dphi0_reg <= dphi0_next;
            dth0_reg  <= dth0_next;
        end
    end

    // ------------------------------------------------------------------
    // Division chain: one quotient bit per cell, MSB first
    // ------------------------------------------------------------------
    usvg_pkg::div_lane_t dphi [usvg_pkg::DIV_STEPS+1];
    usvg_pkg::div_lane_t dth  [usvg_pkg::DIV_STEPS+1];
    usvg_pkg::meta_t     dmeta[usvg_pkg::DIV_STEPS+1];

    assign dphi[0]  = dphi0_reg;
    assign dth[0]   = dth0_reg;
    assign dmeta[0] = meta0_reg;

    for (genvar g = 0; g < usvg_pkg::DIV_STEPS; g++)
    begin : g_div
        usvg_div_cell #(
            .BIT(usvg_pkg::DIV_STEPS - 1 - g)
        ) u_cell (
            .clk      (clk),
            .en       (en[DIV_BASE + g]),
            .phi_in   (dphi[g]),
            .theta_in (dth[g]),
            .meta_in  (dmeta[g]),
            .phi_out  (dphi[g+1]),
            .theta_out(dth[g+1]),
            .meta_out (dmeta[g+1])
        );
    end

    // ------------------------------------------------------------------
    // CORDIC chain: split angle into quadrant and residual, then rotate
    // ------------------------------------------------------------------
    usvg_pkg::cordic_lane_t cphi [usvg_pkg::CORDIC_STEPS+1];
    usvg_pkg::cordic_lane_t cth  [usvg_pkg::CORDIC_STEPS+1];
    usvg_pkg::meta_t        cmeta[usvg_pkg::CORDIC_STEPS+1];

    function automatic usvg_pkg::cordic_lane_t cordic_seed(input logic [15:0] ang);
        usvg_pkg::cordic_lane_t l;
        l.x    = usvg_pkg::CORDIC_GAIN;
        l.y    = '0;
        l.z    = usvg_pkg::Z_W'(ang[13:0]);
        l.quad = ang[15:14];
        l.zero = (ang[13:0] == 14'd0);
        return l;
    endfunction

    assign cphi[0]  = cordic_seed(dphi[usvg_pkg::DIV_STEPS].quo[15:0]);
    assign cth[0]   = cordic_seed(dth[usvg_pkg::DIV_STEPS].quo[15:0]);
    assign cmeta[0] = dmeta[usvg_pkg::DIV_STEPS];

    for (genvar g = 0; g < usvg_pkg::CORDIC_STEPS; g++)
    begin : g_cordic
        usvg_cordic_cell #(
            .K(g)
        ) u_cell (
            .clk      (clk),
            .en       (en[COR_BASE + g]),
            .phi_in   (cphi[g]),
            .theta_in (cth[g]),
            .meta_in  (cmeta[g]),
            .phi_out  (cphi[g+1]),
            .theta_out(cth[g+1]),
            .meta_out (cmeta[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Post stage: clamp, bypass zero residual, fold quadrant
    // ------------------------------------------------------------------
    function automatic logic signed [usvg_pkg::TRIG_W-1:0] clamp_unit(
        input logic signed [usvg_pkg::XY_W-1:0] v
    );
        logic signed [usvg_pkg::XY_W-1:0] c;
        if (v > usvg_pkg::ONE_Q30)
            c = usvg_pkg::ONE_Q30;
        else if (v < -usvg_pkg::ONE_Q30)
            c = -usvg_pkg::ONE_Q30;
        else
            c = v;
        return c[usvg_pkg::TRIG_W-1:0];
    endfunction

    typedef struct packed {
        logic signed [usvg_pkg::TRIG_W-1:0] co;
        logic signed [usvg_pkg::TRIG_W-1:0] si;
    } sincos_t;

    function automatic sincos_t fold(input usvg_pkg::cordic_lane_t l);
        logic signed [usvg_pkg::TRIG_W-1:0] x;
        logic signed [usvg_pkg::TRIG_W-1:0] y;
        sincos_t                            r;
        if (l.zero)
        begin
            x = usvg_pkg::ONE_Q30[usvg_pkg::TRIG_W-1:0];
            y = '0;
        end
        else
        begin
            x = clamp_unit(l.x);
            y = clamp_unit(l.y);
        end
        case (l.quad)
            2'd0:    begin r.co = x;  r.si = y;  end
            2'd1:    begin r.co = -y; r.si = x;  end
            2'd2:    begin r.co = -x; r.si = -y; end
            default: begin r.co = y;  r.si = -x; end
        endcase
        return r;
    endfunction

    sincos_t         sc_phi_reg, sc_th_reg;
    usvg_pkg::meta_t post_meta_reg;

    always_ff @(posedge clk)
    begin
        if (en[POST_STG])
        begin
            sc_phi_reg    <= fold(cphi[usvg_pkg::CORDIC_STEPS]);
            sc_th_reg     <= fold(cth[usvg_pkg::CORDIC_STEPS]);
            post_meta_reg <= cmeta[usvg_pkg::CORDIC_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // M1: unit vector = (sin phi cos theta, cos phi, sin phi sin theta)
    // ------------------------------------------------------------------
    logic signed [63:0]                 px_prod, pz_prod;
    logic signed [63:0]                 px_rnd, pz_rnd;
    logic signed [usvg_pkg::TRIG_W-1:0] ux_reg, uy_reg, uz_reg;
    usvg_pkg::meta_t                    m1_meta_reg;

    always_comb
    begin
        px_prod = 64'(sc_phi_reg.si) * 64'(sc_th_reg.co);
        pz_prod = 64'(sc_phi_reg.si) * 64'(sc_th_reg.si);
        px_rnd  = (px_prod + URND) >>> 30;
        pz_rnd  = (pz_prod + URND) >>> 30;
    end

    always_ff @(posedge clk)
    begin
        if (en[M1_STG])
        begin
            ux_reg      <= px_rnd[usvg_pkg::TRIG_W-1:0];
            uy_reg      <= sc_phi_reg.co;
            uz_reg      <= pz_rnd[usvg_pkg::TRIG_W-1:0];
            m1_meta_reg <= post_meta_reg;
        end
    end

    // ------------------------------------------------------------------
    // M2: scale by radius, round normal
    // ------------------------------------------------------------------
    logic signed [16:0]        rad_s;
    logic signed [PROD_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic signed [NORM_W-1:0]  nx_reg, ny_reg, nz_reg;
    logic signed [32:0]        nx_sum, ny_sum, nz_sum;
    usvg_pkg::meta_t           m2_meta_reg;

    assign rad_s  = $signed({1'b0, sphere_radius_reg});
    assign nx_sum = (33'(ux_reg) + NRND) >>> NSHIFT;
    assign ny_sum = (33'(uy_reg) + NRND) >>> NSHIFT;
    assign nz_sum = (33'(uz_reg) + NRND) >>> NSHIFT;

    always_ff @(posedge clk)
    begin
        if (en[M2_STG])
        begin
            rx_reg      <= PROD_W'(rad_s) * PROD_W'(ux_reg);
            ry_reg      <= PROD_W'(rad_s) * PROD_W'(uy_reg);
            rz_reg      <= PROD_W'(rad_s) * PROD_W'(uz_reg);
            nx_reg      <= nx_sum[NORM_W-1:0];
            ny_reg      <= ny_sum[NORM_W-1:0];
            nz_reg      <= nz_sum[NORM_W-1:0];
            m2_meta_reg <= m1_meta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: round position to Q8.8, zero beats off the grid
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] px_sum, py_sum, pz_sum;
    logic                     keep;

    assign px_sum = (rx_reg + PRND) >>> 30;
    assign py_sum = (ry_reg + PRND) >>> 30;
    assign pz_sum = (rz_reg + PRND) >>> 30;
    assign keep   = m2_meta_reg.in_range;

    always_ff @(posedge clk)
    begin
        if (en[OUT_STG])
        begin
            pos_x      <= keep ? px_sum[usvg_pkg::POS_W-1:0] : '0;
            pos_y      <= keep ? py_sum[usvg_pkg::POS_W-1:0] : '0;
            pos_z      <= keep ? pz_sum[usvg_pkg::POS_W-1:0] : '0;
            norm_x     <= keep ? nx_reg : '0;
            norm_y     <= keep ? ny_reg : '0;
            norm_z     <= keep ? nz_reg : '0;
            corner_a   <= m2_meta_reg.corner_a;
            corner_b   <= m2_meta_reg.corner_b;
            corner_c   <= m2_meta_reg.corner_c;
            corner_d   <= m2_meta_reg.corner_d;
            quad_valid <= m2_meta_reg.quad_valid;
            in_range   <= m2_meta_reg.in_range;
        end
    end

endmodule
